// File: hw/rtl/bsle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsle_pkg
// Shared types, field widths and codes of the bounded sequence list engine.
// ----------------------------------------------------------------------------
package bsle_pkg;

  localparam int BSLE_DEPTH = 32;
  localparam int RESULT_CAP = 32;

  localparam int ACT_W  = 3;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 5;
  localparam int OCC_W  = 6;
  localparam int HIT_W  = $clog2(RESULT_CAP + 1);

  typedef logic [ACT_W-1:0]         action_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [STAT_W-1:0]        status_t;
  typedef logic [IDX_W-1:0]         index_t;
  typedef logic [OCC_W-1:0]         occ_t;

  localparam action_t ACT_PUSH_BACK  = 3'd0;
  localparam action_t ACT_PUSH_FRONT = 3'd1;
  localparam action_t ACT_POP_BACK   = 3'd2;
  localparam action_t ACT_POP_FRONT  = 3'd3;
  localparam action_t ACT_SEARCH     = 3'd4;
  localparam action_t ACT_MODIFY     = 3'd5;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_NOMATCH = 2'd3;

endpackage

// File: hw/rtl/bsle_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsle_in_if
// Command channel: one item carries an action and its operands.
// ----------------------------------------------------------------------------
interface bsle_in_if;
  import bsle_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  word_t   value;
  word_t   new_value;

  modport source (output valid, output action, output value, output new_value,
                  input ready);
  modport sink (input valid, input action, input value, input new_value,
                output ready);
endinterface

// File: hw/rtl/bsle_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsle_out_if
// Result channel: one item per status or search hit.
// ----------------------------------------------------------------------------
interface bsle_out_if;
  import bsle_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  index_t  match_index;
  occ_t    occupancy;
  logic    last_result;

  modport source (output valid, output status, output match_index,
                  output occupancy, output last_result, input ready);
  modport sink (input valid, input status, input match_index,
                input occupancy, input last_result, output ready);
endinterface

// File: hw/rtl/bsle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/bsle_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsle_unit
// Shared datapath: circular address wrap (base + offset mod DEPTH) and the
// word comparator used by the search / modify scan.
// ----------------------------------------------------------------------------
module bsle_unit #(
  parameter int DEPTH = bsle_pkg::BSLE_DEPTH,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic [IW-1:0]     base,
  input  logic [IW-1:0]     offset,
  output logic [IW-1:0]     phys,
  input  bsle_pkg::word_t   a,
  input  bsle_pkg::word_t   b,
  output logic              eq
);
  import bsle_pkg::*;

  logic [IW:0] sum;

  // both operands are below DEPTH, so one subtract is enough
  assign sum  = {1'b0, base} + {1'b0, offset};
  assign phys = (sum >= (IW+1)'(DEPTH)) ? IW'(sum - (IW+1)'(DEPTH)) : sum[IW-1:0];
  assign eq   = (a == b);

endmodule

// File: hw/rtl/bounded_sequence_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sequence_list_engine_core
// Ordered list of up to DEPTH signed words with push/pop at both ends,
// search and modify.
// ----------------------------------------------------------------------------
// The list lives in a single-port-read RAM used as a circular buffer, so
// pushes and pops at either end only move the head pointer or the count and
// never shift data. A command is taken whenever the sequencer is idle, even
// while the previous result still sits in the output register. Push, pop and
// unused actions are accepted, then executed once the output register is free.
// Search and modify walk the list through one shared address/compare unit,
// reading each entry from RAM and then comparing it; modify stops at the
// first hit. Search gives one result per hit (NOMATCH if none), lowest index
// first, at most 32 per command; a stalled result port holds the scan.
// ----------------------------------------------------------------------------
module bounded_sequence_list_engine_core #(
  parameter int DEPTH = bsle_pkg::BSLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  bsle_in_if.sink   cmd,
  bsle_out_if.source rsp
);
  import bsle_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]      state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [IW-1:0]   head, head_next;
  logic [IW-1:0]   idx, idx_next;
  logic [IW-1:0]   pend, pend_next;
  logic            pend_valid, pend_valid_next;
  logic [HIT_W-1:0] hits, hits_next;

  action_t act_r;
  word_t   val_r;
  word_t   nval_r;

  logic    out_valid;
  status_t out_status;
  index_t  out_idx;
  occ_t    out_occ;
  logic    out_last;

  logic            load;
  status_t         ld_status;
  logic [IW-1:0]   ld_idx;
  logic            ld_last;

  logic            we;
  logic [IW-1:0]   waddr;
  word_t           wdata;
  word_t           rdata;

  logic [IW-1:0]   unit_off;
  logic [IW-1:0]   phys;
  logic            eq;

  logic            out_free;
  logic            full;
  logic            empty;
  logic            last_i;
  logic [IW-1:0]   head_dec;
  logic [IW-1:0]   head_inc;

  assign out_free = !out_valid || rsp.ready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign last_i   = ((CW'(idx) + CW'(1)) == count);
  assign head_dec = (head == '0) ? IW'(DEPTH - 1) : head - IW'(1);
  assign head_inc = (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);

  // the unit addresses the back slot while executing, the scan slot otherwise
  assign unit_off = (state == S_EXEC) ? count[IW-1:0] : idx;

  bsle_unit #(.DEPTH(DEPTH)) u_unit (
    .base   (head),
    .offset (unit_off),
    .phys   (phys),
    .a      (rdata),
    .b      (val_r),
    .eq     (eq)
  );

  bsle_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (phys),
    .rdata (rdata)
  );

  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    count_next      = count;
    head_next       = head;
    idx_next        = idx;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    hits_next       = hits;
    load            = 1'b0;
    ld_status       = ST_OK;
    ld_idx          = '0;
    ld_last         = 1'b1;
    we              = 1'b0;
    waddr           = phys;
    wdata           = val_r;

    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_r)
          ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
            if (out_free) begin
              load       = 1'b1;
              state_next = S_IDLE;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + CW'(1);
                if (act_r == ACT_PUSH_FRONT) begin
                  waddr     = head_dec;
                  head_next = head_dec;
                end
              end
            end
          end
          ACT_POP_BACK, ACT_POP_FRONT: begin
            if (out_free) begin
              load       = 1'b1;
              state_next = S_IDLE;
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
                if (act_r == ACT_POP_FRONT) begin
                  head_next = head_inc;
                end
              end
            end
          end
          ACT_SEARCH, ACT_MODIFY: begin
            if (empty) begin
              if (out_free) begin
                load       = 1'b1;
                ld_status  = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              idx_next        = '0;
              hits_next       = '0;
              pend_valid_next = 1'b0;
              state_next      = S_RD;
            end
          end
          default: begin
            if (out_free) begin
              load       = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_RD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (eq) begin
          if (act_r == ACT_MODIFY) begin
            we              = 1'b1;
            wdata           = nval_r;
            pend_next       = idx;
            pend_valid_next = 1'b1;
            state_next      = S_FLUSH;
          end else if (!pend_valid || out_free) begin
            // the previous hit is known not to be the last one now
            if (pend_valid) begin
              load    = 1'b1;
              ld_idx  = pend;
              ld_last = 1'b0;
            end
            pend_next       = idx;
            pend_valid_next = 1'b1;
            hits_next       = hits + HIT_W'(1);
            if (last_i || (hits + HIT_W'(1) == HIT_W'(RESULT_CAP))) begin
              state_next = S_FLUSH;
            end else begin
              idx_next   = idx + IW'(1);
              state_next = S_RD;
            end
          end
        end else if (last_i) begin
          state_next = S_FLUSH;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = S_RD;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
          if (pend_valid) begin
            ld_idx = pend;
          end else begin
            ld_status = ST_NOMATCH;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      head       <= '0;
      pend_valid <= 1'b0;
      hits       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      head       <= head_next;
      pend_valid <= pend_valid_next;
      hits       <= hits_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    pend <= pend_next;
    if (cmd.valid && cmd.ready) begin
      act_r  <= cmd.action;
      val_r  <= cmd.value;
      nval_r <= cmd.new_value;
    end
    if (load) begin
      out_status <= ld_status;
      out_idx    <= IDX_W'(ld_idx);
      out_occ    <= OCC_W'(count_next);
      out_last   <= ld_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.match_index = out_idx;
  assign rsp.occupancy   = out_occ;
  assign rsp.last_result = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (CW'(idx) < count))
    else $error("scan index past list end");

  a_hit_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (hits < HIT_W'(RESULT_CAP)))
    else $error("search kept scanning after hit cap");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |-> !load)
    else $error("result register overwritten while stalled");

endmodule
